// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the status LED RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, skipped while in reset.
`define SLPG_ASSERT(lbl, c, r, prop) \
  lbl: assert property (@(posedge c) disable iff (r) (prop)) \
    else $error("%m: assertion failed");

// Condition that must never be seen outside reset.
`define SLPG_NEVER(lbl, c, r, cond) `SLPG_ASSERT(lbl, c, r, !(cond))

`endif

// ----- hdl/slpg_pkg.sv -----
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants for the status LED pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slpg_pkg;

  // Input transaction layout (tdata bit positions)
  localparam int IN_W          = 72;
  localparam int IN_NOW_LSB    = 0;
  localparam int IN_HELD_BIT   = 32;
  localparam int IN_HOLD_LSB   = 33;
  localparam int IN_LINK_BIT   = 65;
  localparam int IN_PAUSED_BIT = 66;
  localparam int IN_PORTAL_BIT = 67;
  localparam int IN_LOAD_LSB   = 68;
  localparam int OUT_W         = 16;

  // Configuration reset values
  localparam logic [15:0] CONFIRM_RST = 16'd3000;
  localparam logic [15:0] WARN_RST    = 16'd7000;
  localparam logic [15:0] SPEED_RST   = 16'd150;
  localparam logic [15:0] SEARCH_RST  = 16'd1000;

  // Pattern timing
  localparam logic [32:0] CONFIRM_SPAN = 33'd600;
  localparam logic [9:0]  CONFIRM_STEP = 10'd100;
  localparam logic [11:0] BREATH_HALF  = 12'd1500;
  localparam logic [11:0] BREATH_FRAME = 12'd3000;

  // Constant divisors served by the shared unit
  localparam int         DSR_W       = 12;
  localparam logic [2:0] DSEL_WARN   = 3'd0;
  localparam logic [2:0] DSEL_PORTAL = 3'd1;
  localparam logic [2:0] DSEL_BREATH = 3'd2;
  localparam logic [2:0] DSEL_RAMP   = 3'd3;
  localparam logic [2:0] DSEL_DUTY   = 3'd4;

  typedef struct packed {
    logic [15:0] confirm;
    logic [15:0] warn;
    logic [15:0] speed;
    logic [15:0] search;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [2:0]  dsel;
    logic [31:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [31:0]      quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic       valid;
    logic       led;
    logic       pwm;
    logic [7:0] duty;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/slpg_regs.sv -----
// ----------------------------------------------------------------------------
// slpg_regs
// APB register file holding the four timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module slpg_regs
  import slpg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  localparam logic [1:0] REG_CONFIRM = 2'd0;
  localparam logic [1:0] REG_WARN    = 2'd1;
  localparam logic [1:0] REG_SPEED   = 2'd2;
  localparam logic [1:0] REG_SEARCH  = 2'd3;

  logic       wr;
  logic [1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm <= CONFIRM_RST;
      cfg.warn    <= WARN_RST;
      cfg.speed   <= SPEED_RST;
      cfg.search  <= SEARCH_RST;
    end else if (wr) begin
      unique case (idx)
        REG_CONFIRM: cfg.confirm <= pwdata[15:0];
        REG_WARN:    cfg.warn    <= pwdata[15:0];
        REG_SPEED:   cfg.speed   <= pwdata[15:0];
        REG_SEARCH:  cfg.search  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CONFIRM: prdata = {16'b0, cfg.confirm};
      REG_WARN:    prdata = {16'b0, cfg.warn};
      REG_SPEED:   prdata = {16'b0, cfg.speed};
      REG_SEARCH:  prdata = {16'b0, cfg.search};
      default:     prdata = 32'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/slpg_div.sv -----
// ----------------------------------------------------------------------------
// slpg_div
// Shared division by a fixed constant: reciprocal multiply for the quotient,
// then a second pass through the same 32 by 32 multiplier for the remainder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module slpg_div
  import slpg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam logic [1:0] PH_MUL1 = 2'd0;
  localparam logic [1:0] PH_QUOT = 2'd1;
  localparam logic [1:0] PH_MUL2 = 2'd2;
  localparam logic [1:0] PH_REM  = 2'd3;

  // floor(x/d) == (x >> k) * M >> s, exact over the dividend range
  localparam logic [31:0] RCP_WARN   = 32'd429496730;
  localparam logic [31:0] RCP_PORTAL = 32'd274877907;
  localparam logic [31:0] RCP_BREATH = 32'd733007752;
  localparam logic [31:0] RCP_RAMP   = 32'd10486;
  localparam logic [31:0] RCP_DUTY   = 32'd65794;

  localparam logic [31:0] DIV_WARN   = 32'd80;
  localparam logic [31:0] DIV_PORTAL = 32'd2000;
  localparam logic [31:0] DIV_BREATH = 32'd3000;
  localparam logic [31:0] DIV_RAMP   = 32'd100;
  localparam logic [31:0] DIV_DUTY   = 32'd255;

  logic             busy;
  logic             done;
  logic [1:0]       ph;
  logic [2:0]       sel;
  logic [31:0]      dvd;
  logic [31:0]      opa;
  logic [31:0]      opb;
  logic [63:0]      prod;
  logic [31:0]      quot;
  logic [DSR_W-1:0] rem;
  logic [31:0]      pre;
  logic [31:0]      recip;
  logic [31:0]      qcalc;
  logic [31:0]      divisor;
  logic [31:0]      diff;

  always_comb begin
    unique case (req.dsel)
      DSEL_WARN: begin
        pre   = {4'b0, req.dividend[31:4]};
        recip = RCP_WARN;
      end
      DSEL_PORTAL: begin
        pre   = {4'b0, req.dividend[31:4]};
        recip = RCP_PORTAL;
      end
      DSEL_BREATH: begin
        pre   = {3'b0, req.dividend[31:3]};
        recip = RCP_BREATH;
      end
      DSEL_RAMP: begin
        pre   = {2'b0, req.dividend[31:2]};
        recip = RCP_RAMP;
      end
      DSEL_DUTY: begin
        pre   = req.dividend;
        recip = RCP_DUTY;
      end
      default: begin
        pre   = req.dividend;
        recip = '0;
      end
    endcase
  end

  always_comb begin
    unique case (sel)
      DSEL_WARN: begin
        qcalc   = prod[62:31];
        divisor = DIV_WARN;
      end
      DSEL_PORTAL: begin
        qcalc   = {3'b0, prod[63:35]};
        divisor = DIV_PORTAL;
      end
      DSEL_BREATH: begin
        qcalc   = {6'b0, prod[63:38]};
        divisor = DIV_BREATH;
      end
      DSEL_RAMP: begin
        qcalc   = prod[49:18];
        divisor = DIV_RAMP;
      end
      DSEL_DUTY: begin
        qcalc   = prod[55:24];
        divisor = DIV_DUTY;
      end
      default: begin
        qcalc   = '0;
        divisor = '0;
      end
    endcase
  end

  assign diff = dvd - prod[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= PH_MUL1;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        ph   <= PH_MUL1;
      end else if (busy) begin
        if (ph == PH_REM) begin
          busy <= 1'b0;
          done <= 1'b1;
          ph   <= PH_MUL1;
        end else begin
          ph <= ph + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sel <= req.dsel;
      dvd <= req.dividend;
      opa <= pre;
      opb <= recip;
    end else if (busy) begin
      unique case (ph) inside
        PH_MUL1, PH_MUL2: prod <= {32'b0, opa} * {32'b0, opb};
        PH_QUOT: begin
          quot <= qcalc;
          opa  <= qcalc;
          opb  <= divisor;
        end
        PH_REM: rem <= diff[DSR_W-1:0];
      endcase
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

  `SLPG_NEVER(a_start_idle, clk, rst, req.start && busy)
  `SLPG_ASSERT(a_done_end, clk, rst, done |-> (!busy && $past(busy)))
  `SLPG_NEVER(a_idle_phase, clk, rst, !busy && (ph != PH_MUL1))

endmodule

`default_nettype wire

// ----- hdl/slpg_seq.sv -----
// ----------------------------------------------------------------------------
// slpg_seq
// Pattern sequencer: mode priority, LED state and divider scheduling.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module slpg_seq
  import slpg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cfg_t            cfg,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,
  output res_t                 res,
  input  wire logic            res_ready,
  output div_req_t             div_req,
  input  wire div_rsp_t        div_rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] OP_WARN   = 3'd0;
  localparam logic [2:0] OP_PORTAL = 3'd1;
  localparam logic [2:0] OP_FOLD   = 3'd2;
  localparam logic [2:0] OP_RAMP   = 3'd3;
  localparam logic [2:0] OP_DUTY   = 3'd4;

  logic [1:0]  state, state_next;
  logic [2:0]  op, op_next;
  logic        led_level, led_level_next;
  logic        toggle_level, toggle_level_next;
  logic [2:0]  blinks_left, blinks_left_next;
  logic [31:0] last_blink, last_blink_next;
  logic [31:0] last_toggle, last_toggle_next;
  logic        res_pwm, res_pwm_next;
  logic [7:0]  res_duty, res_duty_next;

  logic [31:0] in_now;
  logic        in_held;
  logic [31:0] in_hold;
  logic        in_link;
  logic        in_paused;
  logic        in_portal;

  logic        accept;
  logic [2:0]  load;
  logic [32:0] lo, hi, dur;
  logic        in_confirm;
  logic [9:0]  cdiff;
  logic        confirm_even;
  logic        warn_zone;
  logic        blink_due;
  logic        search_due;
  logic [10:0] pcyc;
  logic        portal_lit;
  logic [11:0] bcyc;
  logic [11:0] bfold;
  logic [10:0] ramp_base;
  logic [15:0] ramp_prod;
  logic [7:0]  bright;
  logic [15:0] bright_sq;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = s_tdata[IN_LOAD_LSB +: 3];

  assign lo           = {17'b0, cfg.confirm};
  assign hi           = lo + CONFIRM_SPAN;
  assign dur          = {1'b0, in_hold};
  assign in_confirm   = (dur >= lo) && (dur < hi);
  assign cdiff        = in_hold[9:0] - cfg.confirm[9:0];
  assign confirm_even = (cdiff < CONFIRM_STEP)
                     || ((cdiff >= 10'd200) && (cdiff < 10'd300))
                     || ((cdiff >= 10'd400) && (cdiff < 10'd500));
  assign warn_zone    = in_hold >= {16'b0, cfg.warn};
  assign blink_due    = (in_now - last_blink) > {16'b0, cfg.speed};
  assign search_due   = (in_now - last_toggle) > {16'b0, cfg.search};

  assign pcyc       = div_rsp.rem[10:0];
  assign portal_lit = (pcyc < 11'd100)
                   || ((pcyc > 11'd200) && (pcyc < 11'd300))
                   || ((pcyc > 11'd400) && (pcyc < 11'd500));

  assign bcyc      = div_rsp.rem;
  assign bfold     = BREATH_FRAME - bcyc;
  assign ramp_base = (bcyc < BREATH_HALF) ? bcyc[10:0] : bfold[10:0];
  // x*255/1500 == x*17/100
  assign ramp_prod = ({5'b0, ramp_base} << 4) + {5'b0, ramp_base};
  assign bright    = div_rsp.quot[7:0];
  assign bright_sq = {8'b0, bright} * {8'b0, bright};

  always_comb begin
    state_next        = state;
    op_next           = op;
    led_level_next    = led_level;
    toggle_level_next = toggle_level;
    blinks_left_next  = blinks_left;
    last_blink_next   = last_blink;
    last_toggle_next  = last_toggle;
    res_pwm_next      = res_pwm;
    res_duty_next     = res_duty;
    div_req           = '0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next    = ST_EVAL;
          res_pwm_next  = 1'b0;
          res_duty_next = 8'd0;
          if (load != 3'd0) begin
            blinks_left_next  = load;
            toggle_level_next = 1'b0;
            last_blink_next   = s_tdata[IN_NOW_LSB +: 32];
            led_level_next    = 1'b0;
          end
        end
      end
      ST_EVAL: begin
        state_next = ST_DONE;
        if (in_held) begin
          if (in_confirm) begin
            led_level_next = confirm_even;
          end else if (warn_zone) begin
            div_req.start    = 1'b1;
            div_req.dividend = in_hold;
            div_req.dsel     = DSEL_WARN;
            op_next          = OP_WARN;
            state_next       = ST_WAIT;
          end else if (dur < lo) begin
            led_level_next = 1'b1;
          end
        end else if (blinks_left != 3'd0) begin
          if (blink_due) begin
            toggle_level_next = ~toggle_level;
            led_level_next    = ~toggle_level;
            last_blink_next   = in_now;
            if (toggle_level) begin
              blinks_left_next = blinks_left - 3'd1;
            end
          end
        end else if (in_portal) begin
          div_req.start    = 1'b1;
          div_req.dividend = in_now;
          div_req.dsel     = DSEL_PORTAL;
          op_next          = OP_PORTAL;
          state_next       = ST_WAIT;
        end else if (in_link) begin
          if (in_paused) begin
            div_req.start    = 1'b1;
            div_req.dividend = in_now;
            div_req.dsel     = DSEL_BREATH;
            op_next          = OP_FOLD;
            state_next       = ST_WAIT;
          end else begin
            led_level_next = 1'b1;
          end
        end else if (search_due) begin
          toggle_level_next = ~toggle_level;
          led_level_next    = ~toggle_level;
          last_toggle_next  = in_now;
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          case (op)
            OP_WARN: begin
              led_level_next = ~div_rsp.quot[0];
              state_next     = ST_DONE;
            end
            OP_PORTAL: begin
              led_level_next = portal_lit;
              state_next     = ST_DONE;
            end
            OP_FOLD: begin
              div_req.start    = 1'b1;
              div_req.dividend = {16'b0, ramp_prod};
              div_req.dsel     = DSEL_RAMP;
              op_next          = OP_RAMP;
            end
            OP_RAMP: begin
              div_req.start    = 1'b1;
              div_req.dividend = {16'b0, bright_sq};
              div_req.dsel     = DSEL_DUTY;
              op_next          = OP_DUTY;
            end
            default: begin
              res_pwm_next  = 1'b1;
              res_duty_next = div_rsp.quot[7:0];
              state_next    = ST_DONE;
            end
          endcase
        end
      end
      default: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_WARN;
      led_level    <= 1'b0;
      toggle_level <= 1'b0;
      blinks_left  <= 3'd0;
      last_blink   <= 32'd0;
      last_toggle  <= 32'd0;
      res_pwm      <= 1'b0;
      res_duty     <= 8'd0;
    end else begin
      state        <= state_next;
      op           <= op_next;
      led_level    <= led_level_next;
      toggle_level <= toggle_level_next;
      blinks_left  <= blinks_left_next;
      last_blink   <= last_blink_next;
      last_toggle  <= last_toggle_next;
      res_pwm      <= res_pwm_next;
      res_duty     <= res_duty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_now    <= s_tdata[IN_NOW_LSB +: 32];
      in_held   <= s_tdata[IN_HELD_BIT];
      in_hold   <= s_tdata[IN_HOLD_LSB +: 32];
      in_link   <= s_tdata[IN_LINK_BIT];
      in_paused <= s_tdata[IN_PAUSED_BIT];
      in_portal <= s_tdata[IN_PORTAL_BIT];
    end
  end

  assign res.valid = (state == ST_DONE);
  assign res.led   = led_level;
  assign res.pwm   = res_pwm;
  assign res.duty  = res_duty;

  `SLPG_ASSERT(a_wait_div, clk, rst, (state == ST_WAIT) |-> (div_rsp.busy || div_rsp.done))
  `SLPG_NEVER(a_idle_div, clk, rst, (state == ST_IDLE) && div_rsp.busy)
  `SLPG_ASSERT(a_duty_off, clk, rst, (res.valid && !res_pwm) |-> (res_duty == 8'd0))

endmodule

`default_nettype wire

// ----- hdl/status_led_pattern_generator_core.sv -----
// ----------------------------------------------------------------------------
// status_led_pattern_generator_core
// Status LED pattern generator: one transaction per millisecond tick in,
// one LED/PWM result transaction out.
//
//  Channel  Dir  Handshake                     Contents
//  s_*      in   s_tvalid/s_tready             tick: time, button, link, load
//  m_*      out  m_tvalid/m_tready             led_lit, pwm_active, pwm_duty
//  APB      in   psel/penable/pwrite/pready    four 16 bit timing registers
//
// Work per tick: speed blink, solid, search and the other hold cases need no
//   division; warning flash and portal mode use one division; breathing uses
//   three divisions, the last on the squared brightness.
// Each constant division takes two passes through the shared multiplier.
// One tick in flight at a time; s_tready is high only while idle.
// A result waiting in the output register stalls the sequencer at its end.
// Reset is synchronous; it clears the LED state and loads the timing registers with their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_generator_core
  import slpg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // APB configuration
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Tick stream in
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // [31:0] now_ms, [32] button_held, [64:33] hold_ms, [65] link_up,
  // [66] jiggle_paused, [67] portal_on, [70:68] blink_load, [71] zero
  input  wire logic [IN_W-1:0]  s_tdata,
  // Result stream out
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // [0] led_lit, [1] pwm_active, [9:2] pwm_duty, [15:10] zero
  output logic [OUT_W-1:0]      m_tdata
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;
  logic     res_ready;

  assign pready    = 1'b1;
  assign res_ready = !m_tvalid || m_tready;

  slpg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  slpg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  slpg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .res       (res),
    .res_ready (res_ready),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_tdata <= {6'b0, res.duty, res.pwm, res.led};
    end
  end

endmodule

`default_nettype wire

// ----- verif/status_led_pattern_generator_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// status_led_pattern_generator_core_tb
// Drives timestamped tick transactions into the LED pattern core and compares
// each result transaction with a cycle-free behavioural prediction. Covers
// the button hold windows, speed blinks, portal blinking, breathing PWM,
// solid and search modes, under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_generator_core_tb;
  import slpg_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 1_500_000;
  localparam int unsigned CONFIRM_SPAN_MS = 600;
  localparam int unsigned CONFIRM_STEP_MS = 100;
  localparam int unsigned WARN_STEP_MS    = 80;
  localparam int unsigned PORTAL_FRAME_MS = 2000;
  localparam int unsigned BREATH_FRAME_MS = 3000;
  localparam int unsigned BREATH_HALF_MS  = 1500;
  localparam int unsigned DUTY_FULL       = 255;

  typedef enum int {REG_CONFIRM = 0, REG_WARN = 1, REG_SPEED = 2, REG_SEARCH = 3} reg_idx_t;

  typedef struct packed {
    logic [31:0] now;
    logic        held;
    logic [31:0] hold;
    logic        link;
    logic        paused;
    logic        portal;
    logic [2:0]  load;
  } tick_t;

  typedef struct packed {
    logic       led;
    logic       pwm;
    logic [7:0] duty;
  } led_out_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // [31:0] now_ms, [32] button_held, [64:33] hold_ms, [65] link_up,
  // [66] jiggle_paused, [67] portal_on, [70:68] blink_load, [71] zero
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // [0] led_lit, [1] pwm_active, [9:2] pwm_duty, [15:10] zero
  logic [OUT_W-1:0] m_tdata;

  status_led_pattern_generator_core DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Predicted block state and registers
  logic        led_lvl = 1'b0;
  logic        toggle_lvl = 1'b0;
  logic [2:0]  blinks_left = '0;
  logic [31:0] last_blink_ms = '0;
  logic [31:0] last_toggle_ms = '0;
  logic [15:0] cfg_confirm = CONFIRM_RST;
  logic [15:0] cfg_warn = WARN_RST;
  logic [15:0] cfg_speed = SPEED_RST;
  logic [15:0] cfg_search = SEARCH_RST;

  led_out_t    pending_leds[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  // Random scene for well-formed tick sequences
  logic [31:0] scene_now = '0;
  logic [31:0] scene_hold = '0;
  logic        scene_held = 1'b0;
  logic        scene_link = 1'b1;
  logic        scene_paused = 1'b0;
  logic        scene_portal = 1'b0;

  function automatic logic [7:0] breath_duty_at(input logic [31:0] now);
    int unsigned pos, lvl;
    pos = now % BREATH_FRAME_MS;
    if (pos < BREATH_HALF_MS) begin
      lvl = pos * DUTY_FULL / BREATH_HALF_MS;
    end else begin
      lvl = (BREATH_FRAME_MS - pos) * DUTY_FULL / BREATH_HALF_MS;
    end
    return 8'(lvl * lvl / DUTY_FULL);
  endfunction

  function automatic logic portal_lit_at(input logic [31:0] now);
    int unsigned pos;
    pos = now % PORTAL_FRAME_MS;
    return pos < 100 || (pos > 200 && pos < 300) || (pos > 400 && pos < 500);
  endfunction

  task automatic predict_leds(input tick_t t);
    led_out_t        res;
    longint unsigned dur, lo;
    logic [31:0]     elapsed;
    res = '0;
    if (t.load != 0) begin
      blinks_left = t.load;
      toggle_lvl = 1'b0;
      last_blink_ms = t.now;
      led_lvl = 1'b0;
    end
    if (t.held) begin
      dur = t.hold;
      lo = cfg_confirm;
      if (dur >= lo && dur < lo + CONFIRM_SPAN_MS) begin
        led_lvl = ((dur - lo) / CONFIRM_STEP_MS) % 2 == 0;
      end else if (dur >= cfg_warn) begin
        led_lvl = (dur / WARN_STEP_MS) % 2 == 0;
      end else if (dur < lo) begin
        led_lvl = 1'b1;
      end
    end else if (blinks_left != 0) begin
      elapsed = t.now - last_blink_ms;
      if (elapsed > cfg_speed) begin
        toggle_lvl = ~toggle_lvl;
        led_lvl = toggle_lvl;
        last_blink_ms = t.now;
        if (!toggle_lvl) blinks_left = blinks_left - 3'd1;
      end
    end else if (t.portal) begin
      led_lvl = portal_lit_at(t.now);
    end else if (t.link) begin
      if (t.paused) begin
        res.pwm = 1'b1;
        res.duty = breath_duty_at(t.now);
      end else begin
        led_lvl = 1'b1;
      end
    end else begin
      elapsed = t.now - last_toggle_ms;
      if (elapsed > cfg_search) begin
        toggle_lvl = ~toggle_lvl;
        led_lvl = toggle_lvl;
        last_toggle_ms = t.now;
      end
    end
    res.led = led_lvl;
    pending_leds.push_back(res);
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic tick_t mk_tick(input logic [31:0] now, input logic held,
                                    input logic [31:0] hold, input logic link,
                                    input logic paused, input logic portal,
                                    input logic [2:0] load);
    tick_t t;
    t.now = now;
    t.held = held;
    t.hold = hold;
    t.link = link;
    t.paused = paused;
    t.portal = portal;
    t.load = load;
    return t;
  endfunction

  // Called just after a rising edge; returns on the edge that accepts it
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, t.load, t.portal, t.paused, t.link, t.hold, t.held, t.now};
    do @(posedge clk); while (!s_tready);
    predict_leds(t);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_leds.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(int'(idx) * 4);
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CONFIRM: cfg_confirm = val;
      REG_WARN:    cfg_warn = val;
      REG_SPEED:   cfg_speed = val;
      REG_SEARCH:  cfg_search = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [15:0] confirm, input logic [15:0] warn,
                                input logic [15:0] speed, input logic [15:0] search);
    drain();
    write_reg(REG_CONFIRM, confirm);
    write_reg(REG_WARN, warn);
    write_reg(REG_SPEED, speed);
    write_reg(REG_SEARCH, search);
  endtask

  task automatic roll_tick(output tick_t t);
    int unsigned r, dt;
    r = $urandom_range(0, 99);
    if (r < 5) dt = 0;
    else if (r < 70) dt = $urandom_range(1, 40);
    else if (r < 95) dt = $urandom_range(41, 400);
    else if (r < 98) dt = $urandom_range(401, 5000);
    else dt = $urandom;
    scene_now = scene_now + dt;
    if ($urandom_range(0, 99) < 3) scene_now = $urandom;
    if ($urandom_range(0, 99) < 4) scene_link = ~scene_link;
    if ($urandom_range(0, 99) < 4) scene_paused = ~scene_paused;
    if ($urandom_range(0, 99) < 3) scene_portal = ~scene_portal;
    if (scene_held) begin
      scene_hold = scene_hold + dt;
      r = $urandom_range(0, 99);
      if (r < 3) scene_held = 1'b0;
      else if (r < 8) scene_hold = 32'(cfg_confirm) + $urandom_range(0, 700);
      else if (r < 11) scene_hold = 32'(cfg_warn) + $urandom_range(0, 400);
      else if (r < 13) scene_hold = $urandom;
    end else if ($urandom_range(0, 99) < 3) begin
      scene_held = 1'b1;
      scene_hold = $urandom_range(0, 50);
    end
    t.now = scene_now;
    t.held = scene_held;
    t.hold = scene_held ? scene_hold : (($urandom_range(0, 3) == 0) ? $urandom : 32'd0);
    t.link = scene_link;
    t.paused = scene_paused;
    t.portal = scene_portal;
    t.load = ($urandom_range(0, 99) < 4) ? 3'($urandom_range(1, 7)) : 3'd0;
  endtask

  task automatic run_random(input int unsigned n);
    tick_t t;
    repeat (n) begin
      roll_tick(t);
      send_tick(t);
    end
  endtask

  task automatic test_hold_patterns();
    send_tick(mk_tick(32'd10, 1'b1, 32'd0, 1'b1, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'd20, 1'b1, 32'd2999, 1'b1, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'd30, 1'b1, 32'd3000, 1'b1, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'd40, 1'b1, 32'd3100, 1'b1, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'd50, 1'b1, 32'd3599, 1'b1, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'd60, 1'b1, 32'd3600, 1'b1, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'd70, 1'b1, 32'd7000, 1'b1, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'd80, 1'b1, 32'd7040, 1'b1, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'd90, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 3'd0));
  endtask

  task automatic test_speed_blinks();
    send_tick(mk_tick(32'd1000, 1'b0, 32'd0, 1'b1, 1'b0, 1'b1, 3'd4));
    send_tick(mk_tick(32'd1150, 1'b0, 32'd0, 1'b1, 1'b0, 1'b1, 3'd0));
    send_tick(mk_tick(32'd1151, 1'b0, 32'd0, 1'b1, 1'b0, 1'b1, 3'd0));
    send_tick(mk_tick(32'd1302, 1'b0, 32'd0, 1'b1, 1'b0, 1'b1, 3'd0));
    // load of seven, then button wins over the blinks
    send_tick(mk_tick(32'd1310, 1'b1, 32'd100, 1'b0, 1'b0, 1'b0, 3'd7));
    send_tick(mk_tick(32'd1461, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 3'd0));
  endtask

  task automatic test_portal_breath();
    send_tick(mk_tick(32'd0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 3'd0));
    send_tick(mk_tick(32'd100, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 3'd0));
    send_tick(mk_tick(32'd250, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 3'd0));
    send_tick(mk_tick(32'd300, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 3'd0));
    send_tick(mk_tick(32'd4450, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1, 3'd0));
    send_tick(mk_tick(32'd0, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 3'd0));
    send_tick(mk_tick(32'd1500, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 3'd0));
    send_tick(mk_tick(32'd2999, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 3'd0));
    send_tick(mk_tick(32'hFFFF_FFFF, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 3'd0));
    send_tick(mk_tick(32'd5000, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, 3'd0));
  endtask

  task automatic test_search_wrap();
    send_tick(mk_tick(32'hFFFF_FF00, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'h0000_0100, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 3'd0));
    send_tick(mk_tick(32'h0000_02F0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 3'd0));
  endtask

  task automatic test_register_extremes();
    write_all_regs(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(150);
    write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(150);
    // confirm window above the warning threshold
    write_all_regs(16'd8000, 16'd1000, 16'd1, 16'd1);
    run_random(150);
  endtask

  task automatic test_random_ticks();
    write_all_regs(CONFIRM_RST, WARN_RST, SPEED_RST, SEARCH_RST);
    run_random(400);
    repeat (3) begin
      write_all_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
      run_random(300);
    end
    drain();
    no_idle = 1'b1;
    write_all_regs(16'd500, 16'd2000, 16'd150, 16'd300);
    run_random(300);
    drain();
    no_idle = 1'b0;
  endtask

  initial begin : rx_pacing
    int unsigned n;
    forever begin
      n = idle_len();
      if (n != 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    led_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_leds.size() == 0) begin
        $display("%0t ns: unexpected result transaction, expected none actual %h",
                 $time, m_tdata);
        fail_count++;
      end else begin
        want = pending_leds.pop_front();
        check_field("led_lit", 8'(want.led), 8'(m_tdata[0]));
        check_field("pwm_active", 8'(want.pwm), 8'(m_tdata[1]));
        check_field("pwm_duty", want.duty, m_tdata[9:2]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_hold_patterns();
    test_speed_blinks();
    test_portal_breath();
    test_search_wrap();
    test_register_extremes();
    test_random_ticks();
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_leds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
